// ----- rtl/stlu_pkg.sv -----
// Shared types and codes of the sorted table ceiling lookup unit.
// Used by the channel interfaces, the table cell and the top level.
package stlu_pkg;

  localparam int KeyWidth    = 32;
  localparam int ValueWidth  = 32;
  localparam int StatusWidth = 3;

  typedef logic signed [KeyWidth-1:0]   key_t;
  typedef logic signed [ValueWidth-1:0] value_t;
  typedef logic [StatusWidth-1:0]       status_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_DUPLICATE = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_FOUND     = 3'd3;
  localparam status_t ST_CLAMPED   = 3'd4;
  localparam status_t ST_EMPTY     = 3'd5;

  // Partial result that travels down the cell row during a scan.
  typedef struct packed {
    logic   found;
    logic   dup;
    key_t   key;
    value_t value;
  } carry_t;

  // Broadcast from the control to every cell.
  typedef struct packed {
    logic   scan;
    logic   ins;
    key_t   key;
    value_t value;
  } cell_ctrl_t;

endpackage

// ----- rtl/stlu_if.sv -----
// Valid/ready channel interfaces of the sorted table ceiling lookup unit.
// Depends on stlu_pkg for the payload types.
interface stlu_in_if import stlu_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   op;
  key_t   key_in;
  value_t value_in;

  modport source (output valid, output op, output key_in, output value_in, input ready);
  modport sink   (input valid, input op, input key_in, input value_in, output ready);
endinterface

interface stlu_out_if import stlu_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  key_t    key_out;
  value_t  value_out;

  modport source (output valid, output status, output key_out, output value_out, input ready);
  modport sink   (input valid, input status, input key_out, input value_out, output ready);
endinterface

// ----- rtl/stlu_cell.sv -----
// One entry of the sorted table: key/value storage, compare against the
// item key, carry stage of the scan and the insert shift. Uses stlu_pkg.
module stlu_cell import stlu_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int IDX   = 0
) (
  input  logic                       clk,
  input  cell_ctrl_t                 ctrl,
  input  logic [$clog2(DEPTH+1)-1:0] count,
  input  logic                       prev_below,
  input  key_t                       prev_key,
  input  value_t                     prev_value,
  input  carry_t                     prev_carry,
  output logic                       below,
  output key_t                       key,
  output value_t                     value,
  output carry_t                     carry
);

  localparam int CW = $clog2(DEPTH+1);

  key_t   key_r;
  value_t value_r;
  carry_t carry_r;
  carry_t carry_nxt;
  logic   occupied;
  logic   sel;
  logic   last;

  assign occupied = CW'(IDX) < count;
  assign below    = occupied && (key_r < ctrl.key);
  // first entry not below the item key
  assign sel      = occupied && !below && prev_below;
  assign last     = count == CW'(IDX + 1);

  always_comb begin
    carry_nxt = prev_carry;
    if (sel) begin
      carry_nxt.found = 1'b1;
      carry_nxt.dup   = key_r == ctrl.key;
      carry_nxt.key   = key_r;
      carry_nxt.value = value_r;
    end else if (last && !prev_carry.found) begin
      // keep the last entry in case nothing is found
      carry_nxt.key   = key_r;
      carry_nxt.value = value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scan) begin
      carry_r <= carry_nxt;
    end
    if (ctrl.ins && !below) begin
      if (prev_below) begin
        key_r   <= ctrl.key;
        value_r <= ctrl.value;
      end else begin
        key_r   <= prev_key;
        value_r <= prev_value;
      end
    end
  end

  assign key   = key_r;
  assign value = value_r;
  assign carry = carry_r;

endmodule

// ----- rtl/sorted_table_ceiling_lookup_unit.sv -----
// Sorted key/value table with ceiling lookup.
// Channels: in_chan (op, key_in, value_in) and out_chan (status, key_out,
// value_out), both valid/ready; an item moves when valid and ready are high
// at a rising clock edge. op 0 inserts a pair at its sorted place, op 1
// returns the entry with the smallest key not below key_in, the last entry
// when key_in is above all keys, or status empty on an empty table.
// Every item gives exactly one result.
// The table is a row of DEPTH cells. After an item is accepted, its partial
// result moves one cell per cycle down the row until it leaves the last
// cell; the finish state then decides the status, shifts the table on an
// insert and loads the output register. One item is handled at a time; the
// length of the cell row sets the length of the scan.
// A stalled receiver holds the result in the output register; the next item
// can still be accepted and scanned, and waits to finish until it is taken.
// Synchronous reset (rst_n low) empties the table and drops any result.
module sorted_table_ceiling_lookup_unit import stlu_pkg::*; #(
  parameter int DEPTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  stlu_in_if.sink    in_chan,
  stlu_out_if.source out_chan
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int IW = $clog2(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t         state_r;
  logic [IW-1:0]  scan_cnt_r;
  logic [CW-1:0]  count_r;
  logic           op_r;
  key_t           key_r;
  value_t         value_r;
  logic           out_valid_r;
  status_t        out_status_r;
  key_t           out_key_r;
  value_t         out_value_r;

  cell_ctrl_t     ctrl;
  logic           cell_below [DEPTH];
  key_t           cell_key   [DEPTH];
  value_t         cell_value [DEPTH];
  carry_t         cell_carry [DEPTH];
  carry_t         fin;
  logic           fire;
  status_t        status;

  assign fin  = cell_carry[DEPTH-1];
  assign fire = (state_r == S_FINISH) && (!out_valid_r || out_chan.ready);

  always_comb begin
    if (op_r == OP_INSERT) begin
      priority if (fin.dup)                    status = ST_DUPLICATE;
      else if (count_r == CW'(DEPTH))          status = ST_FULL;
      else                                     status = ST_INSERTED;
    end else begin
      priority if (count_r == '0)              status = ST_EMPTY;
      else if (fin.found)                      status = ST_FOUND;
      else                                     status = ST_CLAMPED;
    end
  end

  assign ctrl.scan  = state_r == S_SCAN;
  assign ctrl.ins   = fire && (op_r == OP_INSERT) && (status == ST_INSERTED);
  assign ctrl.key   = key_r;
  assign ctrl.value = value_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   prev_below;
    key_t   prev_key;
    value_t prev_value;
    carry_t prev_carry;

    if (i == 0) begin : g_head
      assign prev_below = 1'b1;
      assign prev_key   = key_r;
      assign prev_value = value_r;
      assign prev_carry = '0;
    end else begin : g_body
      assign prev_below = cell_below[i-1];
      assign prev_key   = cell_key[i-1];
      assign prev_value = cell_value[i-1];
      assign prev_carry = cell_carry[i-1];
    end

    stlu_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count_r),
      .prev_below (prev_below),
      .prev_key   (prev_key),
      .prev_value (prev_value),
      .prev_carry (prev_carry),
      .below      (cell_below[i]),
      .key        (cell_key[i]),
      .value      (cell_value[i]),
      .carry      (cell_carry[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_cnt_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_chan.ready && !fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            op_r       <= in_chan.op;
            key_r      <= in_chan.key_in;
            value_r    <= in_chan.value_in;
            scan_cnt_r <= '0;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
          if (scan_cnt_r == IW'(DEPTH - 1)) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fire) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status;
            if (status == ST_FOUND || status == ST_CLAMPED) begin
              out_key_r   <= fin.key;
              out_value_r <= fin.value;
            end else begin
              out_key_r   <= '0;
              out_value_r <= '0;
            end
            if (ctrl.ins) begin
              count_r <= count_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_chan.ready      = state_r == S_IDLE;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.key_out   = out_key_r;
  assign out_chan.value_out = out_value_r;

endmodule

// ----- rtl/stlu_checker.sv -----
// Port-level checks of sorted_table_ceiling_lookup_unit and the bind that
// attaches them. Uses stlu_pkg for the status codes.
module stlu_checker import stlu_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input status_t status,
  input key_t    key_out,
  input value_t  value_out
);

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // nothing selected on insert or empty results
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_INSERTED || status == ST_DUPLICATE ||
                  status == ST_FULL || status == ST_EMPTY)
    |-> key_out == '0 && value_out == '0)
    else $error("result fields not zero when nothing selected");

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
                                $stable(key_out) && $stable(value_out))
    else $error("stalled result changed");

endmodule

bind sorted_table_ceiling_lookup_unit stlu_checker u_stlu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .status    (out_chan.status),
  .key_out   (out_chan.key_out),
  .value_out (out_chan.value_out)
);

// ----- bench/sorted_table_ceiling_lookup_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the sorted table ceiling lookup unit: directed and random inserts and
// queries under varied idling, checked against a table model in a scoreboard class.
// Depends on stlu_pkg, stlu_if and the top level sorted_table_ceiling_lookup_unit.
import stlu_pkg::*;

typedef struct packed {
  status_t status;
  key_t    key;
  value_t  value;
} lookup_result_t;

class lookup_scoreboard;
  localparam int Entries = 64;

  key_t           keys[Entries];
  value_t         vals[Entries];
  int             fill;
  lookup_result_t expected_q[$];
  int unsigned    errors;

  function new();
    fill   = 0;
    errors = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Apply one accepted item to the table copy and queue its result.
  function void note_item(logic op, key_t k, value_t v);
    lookup_result_t r;
    int             pos;
    r   = '0;
    pos = fill;
    for (int i = fill - 1; i >= 0; i--) begin
      if (keys[i] >= k) pos = i;
    end
    if (op == OP_INSERT) begin
      if (pos < fill && keys[pos] == k) begin
        r.status = ST_DUPLICATE;
      end else if (fill == Entries) begin
        r.status = ST_FULL;
      end else begin
        for (int i = fill; i > pos; i--) begin
          keys[i] = keys[i-1];
          vals[i] = vals[i-1];
        end
        keys[pos] = k;
        vals[pos] = v;
        fill++;
        r.status = ST_INSERTED;
      end
    end else if (fill == 0) begin
      r.status = ST_EMPTY;
    end else if (pos == fill) begin
      r.status = ST_CLAMPED;
      r.key    = keys[fill-1];
      r.value  = vals[fill-1];
    end else begin
      r.status = ST_FOUND;
      r.key    = keys[pos];
      r.value  = vals[pos];
    end
    expected_q.push_back(r);
  endfunction

  function void check_result(lookup_result_t got);
    lookup_result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result: status %0d key %h value %h",
               $time, got.status, got.key, got.value);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, got.status);
      errors++;
    end
    if (got.key !== want.key) begin
      $display("%0t: key_out mismatch: expected %h, got %h", $time, want.key, got.key);
      errors++;
    end
    if (got.value !== want.value) begin
      $display("%0t: value_out mismatch: expected %h, got %h", $time, want.value, got.value);
      errors++;
    end
  endfunction
endclass

module sorted_table_ceiling_lookup_unit_tb;
  localparam int   TABLE_DEPTH = 64;
  localparam key_t KEY_MIN     = 32'sh8000_0000;
  localparam key_t KEY_MAX     = 32'sh7FFF_FFFF;
  localparam key_t KEY_ONE     = 32'sh0001_0000;

  logic clk;
  logic rst_n;

  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;

  stlu_in_if  in_if();
  stlu_out_if out_if();

  lookup_scoreboard table_sb = new();

  sorted_table_ceiling_lookup_unit #(.DEPTH(TABLE_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL sorted_table_ceiling_lookup_unit");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when hold_left is loaded.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        table_sb.note_item(in_if.op, in_if.key_in, in_if.value_in);
      if (out_if.valid && out_if.ready)
        table_sb.check_result({out_if.status, out_if.key_out, out_if.value_out});
    end
  end

  task automatic send_item(input logic op, input key_t k, input value_t v);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.op       <= op;
    in_if.key_in   <= k;
    in_if.value_in <= v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Hold the sender until every queued result has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (table_sb.pending() != 0);
  endtask

  function automatic key_t pick_key(bit for_query);
    int unsigned sel;
    key_t        k;
    sel = $urandom_range(99);
    if (table_sb.fill > 0 && sel < 50) begin
      k = table_sb.keys[$urandom_range(table_sb.fill - 1)];
      // Step next to a stored key now and then to hit the boundaries.
      if (sel >= 35) k = $urandom_range(1) ? k + 1 : k - 1;
      return k;
    end
    if (sel < 62) begin
      case ($urandom_range(3))
        0:       return KEY_MIN;
        1:       return '0;
        2:       return -1;
        default: return for_query ? KEY_MAX : key_t'($urandom);
      endcase
    end
    return $urandom;
  endfunction

  function automatic value_t pick_value();
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7FFF_FFFF;
        2:       return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic run_random(input int n_items, input int hold_at);
    logic op;
    key_t k;
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) hold_left = 400;
      op = ($urandom_range(99) < (table_sb.fill < TABLE_DEPTH ? 50 : 35)) ? OP_INSERT
                                                                           : OP_QUERY;
      k  = pick_key(op == OP_QUERY);
      send_item(op, k, pick_value());
    end
  endtask

  initial begin
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_left       = 0;
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.op       <= OP_INSERT;
    in_if.key_in   <= '0;
    in_if.value_in <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, exact hits, ceilings, clamping and a duplicate.
    send_item(OP_QUERY,  '0,             32'sh1234_5678);
    send_item(OP_QUERY,  KEY_MAX,        '0);
    send_item(OP_INSERT, KEY_ONE,        32'sh7FFF_FFFF);
    send_item(OP_QUERY,  KEY_MIN,        '0);
    send_item(OP_QUERY,  KEY_ONE,        '0);
    send_item(OP_QUERY,  KEY_ONE + 1,    '0);
    send_item(OP_INSERT, KEY_MIN,        32'sh8000_0000);
    send_item(OP_INSERT, -1,             '0);
    send_item(OP_INSERT, '0,             -1);
    send_item(OP_INSERT, KEY_ONE,        32'sh1234_5678);
    send_item(OP_QUERY,  KEY_MIN,        -1);
    send_item(OP_QUERY,  KEY_MIN + 1,    '0);
    send_item(OP_QUERY,  -1,             '0);
    send_item(OP_QUERY,  32'sh0000_8000, '0);
    send_item(OP_QUERY,  KEY_MAX,        '0);
    send_item(OP_INSERT, 32'sh0002_0000, 32'shAAAA_AAAA);
    send_item(OP_INSERT, 32'sh0001_8000, 32'sh5555_5555);
    send_item(OP_QUERY,  32'sh0001_4000, '0);
    send_item(OP_QUERY,  32'sh0002_0000, '0);
    send_item(OP_QUERY,  KEY_MAX,        '0);
    wait_drained();

    // Random phases; the first one also holds the receiver off for a long stretch.
    run_random(133, 60);
    wait_drained();
    sender_idle_pct = 64;
    run_random(133, -1);
    wait_drained();
    sender_idle_pct = 0;
    recv_stall_pct  = 64;
    run_random(133, -1);
    wait_drained();
    sender_idle_pct = 30;
    recv_stall_pct  = 30;
    run_random(133, -1);

    wait_drained();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (table_sb.errors == 0 && table_sb.pending() == 0) begin
      $display("PASS sorted_table_ceiling_lookup_unit");
    end else begin
      $display("FAIL sorted_table_ceiling_lookup_unit");
    end
    $finish;
  end
endmodule

// ----- sorted_table_ceiling_lookup_unit.f -----
rtl/stlu_pkg.sv
rtl/stlu_if.sv
rtl/stlu_cell.sv
rtl/sorted_table_ceiling_lookup_unit.sv
rtl/stlu_checker.sv
bench/sorted_table_ceiling_lookup_unit_tb.sv
